FILE: hw/rtl/fbpa_pkg.sv
// ----------------------------------------------------------------------------
// fbpa_pkg
// Shared types and constants of the fixed block pool allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package fbpa_pkg;

    // Operation codes carried in the input item.
    typedef enum logic [1:0] {
        OP_ALLOC   = 2'd0,
        OP_REALLOC = 2'd1,
        OP_FREE    = 2'd2,
        OP_INIT    = 2'd3
    } op_t;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_POP,
        ST_WALK
    } state_t;

    // Configuration register indexes.
    localparam logic CFG_BLOCK_BYTES   = 1'b0;
    localparam logic CFG_BLOCKS_IN_USE = 1'b1;

    // Smallest legal block size: a block must hold one free-list pointer.
    localparam int unsigned PTR_BYTES = 8;

    // The active count saturates here.
    localparam logic [8:0] COUNT_MAX = 9'h1FF;

    // Reset values of the configuration registers.
    localparam logic [15:0] BLOCK_BYTES_RST   = 16'd16;
    localparam logic [8:0]  BLOCKS_IN_USE_RST = 9'd256;

    // One result item as it leaves the controller.
    typedef struct packed {
        logic       ok;
        logic [7:0] granted_index;
        logic [8:0] active_count;
    } res_t;

endpackage

`default_nettype wire

FILE: hw/rtl/fbpa_link_ram.sv
// ----------------------------------------------------------------------------
// fbpa_link_ram
// Next-link table of the free list: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module fbpa_link_ram #(
    parameter int DEPTH = 256,
    parameter int AW    = 8,
    parameter int DW    = 9
) (
    input  wire logic          aclk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [DW-1:0] wdata,
    input  wire logic          re,
    input  wire logic [AW-1:0] raddr,
    output logic      [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Read port with registered read data.
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/fbpa_ctrl.sv
// ----------------------------------------------------------------------------
// fbpa_ctrl
// Free-list controller: holds the head, the active count and the pool size,
// runs alloc, realloc, free and the init walk against the link table.
// ----------------------------------------------------------------------------
`default_nettype none

module fbpa_ctrl #(
    parameter int MAX_BLOCKS = 256,
    parameter int AW         = 8,
    parameter int LW         = 9
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    // Item handshake
    input  wire logic            accept,
    output logic                 idle,
    input  wire logic [1:0]      in_op,
    input  wire logic [15:0]     in_request_bytes,
    input  wire logic            in_has_block,
    input  wire logic [7:0]      in_block_index,
    // Configuration
    input  wire logic [15:0]     block_bytes,
    input  wire logic [8:0]      blocks_in_use,
    // Result
    output logic                 res_valid,
    output fbpa_pkg::res_t       res,
    // Link table
    output logic                 mem_we,
    output logic      [AW-1:0]   mem_waddr,
    output logic      [LW-1:0]   mem_wdata,
    output logic                 mem_re,
    output logic      [AW-1:0]   mem_raddr,
    input  wire logic [LW-1:0]   mem_rdata
);

    import fbpa_pkg::*;

    localparam logic [LW-1:0] LINK_NULL = LW'(MAX_BLOCKS);

    state_t        state_reg, state_next;
    logic [LW-1:0] head_reg, head_next;
    logic [8:0]    count_reg, count_next;
    logic [15:0]   pool_reg, pool_next;
    logic [AW-1:0] walk_reg, walk_next;
    logic [AW-1:0] last_reg, last_next;

    logic          fits;
    logic          list_empty;
    logic          in_range;
    logic [LW-1:0] n_lim;
    op_t           op;

    assign op         = op_t'(in_op);
    assign fits       = (in_request_bytes <= pool_reg);
    assign list_empty = (head_reg == LINK_NULL);
    assign in_range   = (32'(in_block_index) < MAX_BLOCKS);
    assign n_lim      = (32'(blocks_in_use) > MAX_BLOCKS) ? LINK_NULL : LW'(blocks_in_use);
    assign idle       = (state_reg == ST_IDLE);

    // State and data registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            head_reg  <= LINK_NULL;
            count_reg <= '0;
            pool_reg  <= '0;
        end else begin
            state_reg <= state_next;
            head_reg  <= head_next;
            count_reg <= count_next;
            pool_reg  <= pool_next;
        end
    end

    always_ff @(posedge aclk) begin
        walk_reg <= walk_next;
        last_reg <= last_next;
    end

    // Next state, table accesses and results.
    always_comb begin
        state_next = state_reg;
        head_next  = head_reg;
        count_next = count_reg;
        pool_next  = pool_reg;
        walk_next  = walk_reg;
        last_next  = last_reg;
        mem_we     = 1'b0;
        mem_waddr  = AW'(in_block_index);
        mem_wdata  = head_reg;
        mem_re     = 1'b0;
        mem_raddr  = head_reg[AW-1:0];
        res_valid  = 1'b0;
        res        = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    unique case (op)
                        OP_ALLOC, OP_REALLOC: begin
                            if (op == OP_REALLOC && in_has_block) begin
                                // Keep the block when the new size fits.
                                res_valid          = 1'b1;
                                res.ok             = fits;
                                res.granted_index  = fits ? in_block_index : 8'd0;
                                res.active_count   = count_reg;
                            end else if (fits && !list_empty) begin
                                // Pop: fetch the link of the head block.
                                mem_re     = 1'b1;
                                state_next = ST_POP;
                                if (count_reg != COUNT_MAX) begin
                                    count_next = count_reg + 9'd1;
                                end
                            end else begin
                                res_valid        = 1'b1;
                                res.active_count = count_reg;
                            end
                        end
                        OP_FREE: begin
                            // Push the block onto the list.
                            if (in_has_block && in_range) begin
                                mem_we    = 1'b1;
                                head_next = LW'(in_block_index);
                                if (count_reg != 9'd0) begin
                                    count_next = count_reg - 9'd1;
                                end
                            end
                            res_valid        = 1'b1;
                            res.ok           = 1'b1;
                            res.active_count = count_next;
                        end
                        OP_INIT: begin
                            if (32'(block_bytes) < PTR_BYTES || blocks_in_use == 9'd0) begin
                                res_valid        = 1'b1;
                                res.active_count = count_reg;
                            end else begin
                                // Latch the pool and start linking blocks.
                                pool_next        = block_bytes;
                                count_next       = '0;
                                head_next        = n_lim - LW'(1);
                                last_next        = AW'(n_lim - LW'(1));
                                walk_next        = '0;
                                state_next       = ST_WALK;
                                res_valid        = 1'b1;
                                res.ok           = 1'b1;
                            end
                        end
                    endcase
                end
            end
            ST_POP: begin
                // The link read last cycle becomes the new head.
                head_next         = mem_rdata;
                res_valid         = 1'b1;
                res.ok            = 1'b1;
                res.granted_index = 8'(head_reg);
                res.active_count  = count_reg;
                state_next        = ST_IDLE;
            end
            ST_WALK: begin
                // Each block links to the one below it; block zero ends the list.
                mem_we    = 1'b1;
                mem_waddr = walk_reg;
                mem_wdata = (walk_reg == '0) ? LINK_NULL : LW'(walk_reg) - LW'(1);
                walk_next = walk_reg + AW'(1);
                if (walk_reg == last_reg) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: hw/rtl/fixed_block_pool_allocator_unit.sv
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator_unit
// An alloc or realloc that pops the free list gives its result from ST_POP, after the
// registered read of the link table; every other item, a rejected init too, gives it from ST_IDLE.
// Init gives its result at once, then walks the table, writing min(blocks_in_use,
// MAX_BLOCKS) links, one link write per cycle, before the next item.
// A result held in the output register stalls the next item until it is taken.
// Reset empties the free list, clears the active count and the pool size.
// ----------------------------------------------------------------------------
`default_nettype none

module fixed_block_pool_allocator_unit #(
    parameter int MAX_BLOCKS = 256
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Configuration write port
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [15:0] cfg_wdata,
    // Input items
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // op[1:0], request_bytes[17:2], block_index[25:18]
    input  wire logic        s_tuser,   // has_block[0]
    // Result items
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [23:0] m_tdata,   // granted_index[7:0], active_count[16:8]
    output logic             m_tuser    // ok[0]
);

    import fbpa_pkg::*;

    localparam int AW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int LW = $clog2(MAX_BLOCKS + 1);

    logic [15:0]   block_bytes_reg;
    logic [8:0]    blocks_in_use_reg;
    logic          m_valid_reg;
    res_t          m_res_reg;
    logic          out_free;
    logic          idle;
    logic          accept;
    logic          res_valid;
    res_t          res;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [LW-1:0] mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;
    logic [LW-1:0] mem_rdata;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            block_bytes_reg   <= BLOCK_BYTES_RST;
            blocks_in_use_reg <= BLOCKS_IN_USE_RST;
        end else if (cfg_we) begin
            if (cfg_index == CFG_BLOCK_BYTES) begin
                block_bytes_reg <= cfg_wdata;
            end else begin
                blocks_in_use_reg <= cfg_wdata[8:0];
            end
        end
    end

    // An item is taken only when the output register can hold its result.
    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = idle && out_free;
    assign accept   = s_tvalid && s_tready;

    fbpa_ctrl #(
        .MAX_BLOCKS (MAX_BLOCKS),
        .AW         (AW),
        .LW         (LW)
    ) u_ctrl (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .accept           (accept),
        .idle             (idle),
        .in_op            (s_tdata[1:0]),
        .in_request_bytes (s_tdata[17:2]),
        .in_has_block     (s_tuser),
        .in_block_index   (s_tdata[25:18]),
        .block_bytes      (block_bytes_reg),
        .blocks_in_use    (blocks_in_use_reg),
        .res_valid        (res_valid),
        .res              (res),
        .mem_we           (mem_we),
        .mem_waddr        (mem_waddr),
        .mem_wdata        (mem_wdata),
        .mem_re           (mem_re),
        .mem_raddr        (mem_raddr),
        .mem_rdata        (mem_rdata)
    );

    fbpa_link_ram #(
        .DEPTH (MAX_BLOCKS),
        .AW    (AW),
        .DW    (LW)
    ) u_link_ram (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_valid) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid) begin
            m_res_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'd0, m_res_reg.active_count, m_res_reg.granted_index};
    assign m_tuser  = m_res_reg.ok;

endmodule

`default_nettype wire

FILE: verif/fixed_block_pool_allocator_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator_unit_test
// Self-checking bench for the block pool allocator. A behavioral copy of the
// free list predicts every reply; directed items cover the unconfigured pool,
// the init checks, size extremes, count saturation and a long receiver hold, then
// random phases of mostly well-formed alloc, realloc and free traffic run under
// random stalls on both sides.
// ----------------------------------------------------------------------------
`default_nettype none

module fixed_block_pool_allocator_unit_test;

    import fbpa_pkg::*;

    localparam int         POOL_SLOTS   = 256;
    localparam logic [8:0] NO_LINK      = 9'd256;
    // Cycles to let an init walk finish after its reply has come.
    localparam int         WALK_SETTLE  = 300;
    localparam int         RANDOM_ITEMS = 80;

    logic        aclk;
    logic        aresetn;
    logic        cfg_we;
    logic        cfg_index;
    logic [15:0] cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;   // op[1:0], request_bytes[17:2], block_index[25:18]
    logic        s_tuser;   // has_block[0]
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;   // granted_index[7:0], active_count[16:8]
    logic        m_tuser;   // ok[0]

    // Replies predicted for accepted items, oldest first.
    res_t        predicted_replies[$];
    int          failures;
    bit          no_idle;
    int          hold_cycles;

    // Bench copy of the allocator state and its configuration.
    logic [8:0]  link_tbl[POOL_SLOTS];
    logic [8:0]  head_link;
    logic [8:0]  live_count;
    logic [15:0] pool_size;
    logic [15:0] cfg_block_bytes;
    logic [8:0]  cfg_block_count;

    // Blocks the stimulus believes are handed out.
    logic [7:0]  held_blocks[$];

    fixed_block_pool_allocator_unit #(
        .MAX_BLOCKS(POOL_SLOTS)
    ) u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Pop the head of the free list when the request fits the pool size.
    function automatic res_t take_block(input logic [15:0] req);
        res_t r;
        r = '0;
        if (req <= pool_size && head_link < NO_LINK) begin
            r.ok            = 1'b1;
            r.granted_index = head_link[7:0];
            head_link       = link_tbl[head_link[7:0]];
            if (live_count != COUNT_MAX) live_count++;
        end
        return r;
    endfunction

    // Advance the bench copy by one item and return the reply it gives.
    function automatic res_t allocator_step(input op_t op, input logic [15:0] req,
                                            input logic has, input logic [7:0] idx);
        res_t r;
        int   n;
        r = '0;
        case (op)
            OP_ALLOC: begin
                r = take_block(req);
            end
            OP_REALLOC: begin
                if (!has) begin
                    r = take_block(req);
                end else if (req <= pool_size) begin
                    r.ok            = 1'b1;
                    r.granted_index = idx;
                end
            end
            OP_FREE: begin
                // Any index of the table is pushed, double frees included.
                if (has) begin
                    link_tbl[idx] = head_link;
                    head_link     = {1'b0, idx};
                    if (live_count != 0) live_count--;
                end
                r.ok = 1'b1;
            end
            default: begin
                // A bad configuration leaves everything as it was.
                if (cfg_block_bytes >= PTR_BYTES && cfg_block_count != 0) begin
                    n          = (cfg_block_count > POOL_SLOTS) ? POOL_SLOTS : cfg_block_count;
                    pool_size  = cfg_block_bytes;
                    live_count = '0;
                    head_link  = NO_LINK;
                    for (int i = 0; i < n; i++) begin
                        link_tbl[i] = head_link;
                        head_link   = 9'(i);
                    end
                    r.ok = 1'b1;
                end
            end
        endcase
        r.active_count = live_count;
        return r;
    endfunction

    // Offer one item after a random gap and predict its reply once it is taken.
    task automatic send_item(input op_t op, input logic [15:0] req,
                             input logic has, input logic [7:0] idx);
        int   gap;
        bit   taken;
        res_t want;
        gap = no_idle ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, idx, req, op};
        s_tuser  <= has;
        do begin
            @(negedge aclk);
            taken = (s_tready === 1'b1);
            if (taken) begin
                want = allocator_step(op, req, has, idx);
                predicted_replies.push_back(want);
                if (want.ok && (op == OP_ALLOC || (op == OP_REALLOC && !has)))
                    held_blocks.push_back(want.granted_index);
                else if (want.ok && op == OP_INIT)
                    held_blocks.delete();
            end
            @(posedge aclk);
        end while (!taken);
    endtask

    task automatic drain_replies();
        s_tvalid <= 1'b0;
        while (predicted_replies.size() != 0) @(posedge aclk);
    endtask

    // Configuration may only change once any init walk has finished.
    task automatic settle_idle();
        drain_replies();
        repeat (WALK_SETTLE) @(posedge aclk);
    endtask

    task automatic write_reg(input logic idx, input logic [15:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (idx == CFG_BLOCK_BYTES)
            cfg_block_bytes = value;
        else
            cfg_block_count = value[8:0];
        @(posedge aclk);
    endtask

    // Remove and return a random held block, or a random index if none is held.
    function automatic logic [7:0] release_pick();
        int k;
        logic [7:0] b;
        if (held_blocks.size() == 0) return 8'($urandom_range(0, 255));
        k = $urandom_range(0, held_blocks.size() - 1);
        b = held_blocks[k];
        held_blocks.delete(k);
        return b;
    endfunction

    // An unconfigured pool has an empty list and a size of zero.
    task automatic test_before_init();
        send_item(OP_ALLOC,   16'd0, 1'b0, 8'd0);
        send_item(OP_REALLOC, 16'd0, 1'b0, 8'd0);
        send_item(OP_REALLOC, 16'd0, 1'b1, 8'hAA);
        send_item(OP_REALLOC, 16'd1, 1'b1, 8'h55);
        send_item(OP_FREE,    16'd0, 1'b0, 8'hFF);
    endtask

    // Init rejects a block smaller than a pointer and a zero count, and
    // clips a count above POOL_SLOTS.
    task automatic test_init_checks();
        settle_idle();
        write_reg(CFG_BLOCK_BYTES, 16'd7);
        send_item(OP_INIT, 16'd0, 1'b0, 8'd0);
        settle_idle();
        write_reg(CFG_BLOCK_BYTES, 16'd8);
        write_reg(CFG_BLOCKS_IN_USE, 16'd0);
        send_item(OP_INIT, 16'd0, 1'b0, 8'd0);
        settle_idle();
        write_reg(CFG_BLOCKS_IN_USE, 16'd511);
        send_item(OP_INIT,    16'hFFFF, 1'b1, 8'hFF);
        send_item(OP_ALLOC,   16'd8,    1'b0, 8'd0);
        send_item(OP_ALLOC,   16'd9,    1'b0, 8'd0);
        send_item(OP_FREE,    16'd0,    1'b1, 8'd255);
        send_item(OP_ALLOC,   16'd0,    1'b0, 8'd0);
        send_item(OP_REALLOC, 16'd9,    1'b1, 8'd255);
    endtask

    // Largest block size with a single block; a free outside the pool is
    // pushed like any other.
    task automatic test_size_extremes();
        settle_idle();
        write_reg(CFG_BLOCK_BYTES, 16'hFFFF);
        write_reg(CFG_BLOCKS_IN_USE, 16'd1);
        send_item(OP_INIT,  16'd0,    1'b0, 8'd0);
        send_item(OP_ALLOC, 16'hFFFF, 1'b0, 8'd0);
        send_item(OP_ALLOC, 16'd0,    1'b0, 8'd0);
        send_item(OP_FREE,  16'd0,    1'b1, 8'd200);
        send_item(OP_ALLOC, 16'd1,    1'b0, 8'd0);
        send_item(OP_FREE,  16'd0,    1'b0, 8'd77);
    endtask

    // A double free of one block links it to itself, so allocs never run
    // dry and the active count reaches its ceiling. No idling here.
    task automatic test_count_saturation();
        settle_idle();
        no_idle = 1'b1;
        send_item(OP_INIT,  16'd0, 1'b0, 8'd0);
        send_item(OP_ALLOC, 16'd8, 1'b0, 8'd0);
        send_item(OP_FREE,  16'd0, 1'b1, 8'd0);
        send_item(OP_FREE,  16'd0, 1'b1, 8'd0);
        repeat (515) send_item(OP_ALLOC, 16'd8, 1'b0, 8'd0);
        send_item(OP_FREE,  16'd0, 1'b1, 8'd0);
        no_idle = 1'b0;
    endtask

    // The receiver stops for a long stretch while items keep coming, then
    // the sender waits for every reply.
    task automatic test_backpressure();
        settle_idle();
        write_reg(CFG_BLOCK_BYTES, 16'd64);
        write_reg(CFG_BLOCKS_IN_USE, 16'd12);
        send_item(OP_INIT, 16'd0, 1'b0, 8'd0);
        hold_cycles = 80;
        for (int i = 0; i < 20; i++) begin
            if (i < 12)
                send_item(OP_ALLOC, 16'($urandom_range(0, 64)), 1'b0, 8'd0);
            else
                send_item(OP_FREE, 16'($urandom_range(0, 65535)), 1'b1, release_pick());
        end
        drain_replies();
    endtask

    // Random phases: a new configuration, an init, then mostly well-formed
    // traffic on the held blocks with some noise mixed in.
    task automatic test_random_traffic();
        int          sent;
        int          burst;
        int          pick;
        logic [15:0] value;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            settle_idle();
            pick = $urandom_range(0, 9);
            if (pick != 0) begin
                if (pick == 1)      value = 16'($urandom_range(0, 7));
                else if (pick == 2) value = 16'hFFFF;
                else if (pick == 3) value = 16'd8;
                else                value = 16'($urandom_range(8, 65535));
                write_reg(CFG_BLOCK_BYTES, value);
            end
            pick = $urandom_range(0, 15);
            if (pick != 3) begin
                if (pick == 0)      value = 16'd0;
                else if (pick == 1) value = 16'd256;
                else if (pick == 2) value = 16'($urandom_range(257, 511));
                else                value = 16'($urandom_range(1, 24));
                write_reg(CFG_BLOCKS_IN_USE, value);
            end
            no_idle = ($urandom_range(0, 7) == 0);
            send_item(OP_INIT, 16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)),
                      8'($urandom_range(0, 255)));
            burst = $urandom_range(15, 40);
            repeat (burst) begin
                pick  = $urandom_range(0, 99);
                value = (pick % 5 == 0) ? 16'($urandom_range(0, 65535))
                                        : 16'($urandom_range(0, pool_size));
                if (pick < 35) begin
                    send_item(OP_ALLOC, value, 1'($urandom_range(0, 1)),
                              8'($urandom_range(0, 255)));
                end else if (pick < 55) begin
                    send_item(OP_FREE, value, 1'b1, release_pick());
                end else if (pick < 65) begin
                    send_item(OP_REALLOC, value, 1'b1,
                              held_blocks.size() != 0 ? held_blocks[0]
                                                      : 8'($urandom_range(0, 255)));
                end else if (pick < 70) begin
                    send_item(OP_REALLOC, value, 1'b0, 8'($urandom_range(0, 255)));
                end else if (pick < 80) begin
                    send_item(OP_FREE, value, 1'($urandom_range(0, 1)),
                              8'($urandom_range(0, 255)));
                end else begin
                    send_item(op_t'($urandom_range(0, 3)), 16'($urandom_range(0, 65535)),
                              1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
                end
            end
            sent += burst + 1;
        end
        no_idle = 1'b0;
    endtask

    // Receiver: random stall before each reply, plus a long hold on request.
    initial begin : reply_sink
        int gap;
        bit took;
        m_tready = 1'b0;
        @(posedge aclk);
        forever begin
            if (hold_cycles > 0) begin
                m_tready <= 1'b0;
                repeat (hold_cycles) @(posedge aclk);
                hold_cycles = 0;
            end
            gap = no_idle ? 0 : $urandom_range(0, 11);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do begin
                @(negedge aclk);
                took = (m_tvalid === 1'b1);
                @(posedge aclk);
            end while (!took && hold_cycles == 0);
        end
    end

    // Compare each reply taken at a clock edge with the oldest prediction.
    initial begin : reply_checker
        res_t        want;
        bit          seen;
        logic [23:0] got_data;
        logic        got_ok;
        forever begin
            @(negedge aclk);
            seen     = (m_tvalid === 1'b1) && (m_tready === 1'b1);
            got_data = m_tdata;
            got_ok   = m_tuser;
            @(posedge aclk);
            if (seen) begin
                if (predicted_replies.size() == 0) begin
                    $error("reply with none predicted: ok=%0d granted_index=%0d active_count=%0d",
                           got_ok, got_data[7:0], got_data[16:8]);
                    failures++;
                end else begin
                    want = predicted_replies.pop_front();
                    if (got_ok !== want.ok) begin
                        $error("ok: expected %0d, got %0d", want.ok, got_ok);
                        failures++;
                    end
                    if (got_data[7:0] !== want.granted_index) begin
                        $error("granted_index: expected %0d, got %0d",
                               want.granted_index, got_data[7:0]);
                        failures++;
                    end
                    if (got_data[16:8] !== want.active_count) begin
                        $error("active_count: expected %0d, got %0d",
                               want.active_count, got_data[16:8]);
                        failures++;
                    end
                end
            end
        end
    end

    initial begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

    initial begin
        aresetn         = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = 1'b0;
        cfg_wdata       = '0;
        s_tvalid        = 1'b0;
        s_tdata         = '0;
        s_tuser         = 1'b0;
        failures        = 0;
        no_idle         = 1'b0;
        hold_cycles     = 0;
        head_link       = NO_LINK;
        live_count      = '0;
        pool_size       = '0;
        cfg_block_bytes = BLOCK_BYTES_RST;
        cfg_block_count = BLOCKS_IN_USE_RST;
        for (int i = 0; i < POOL_SLOTS; i++) link_tbl[i] = '0;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_before_init();
        test_init_checks();
        test_size_extremes();
        test_count_saturation();
        test_backpressure();
        test_random_traffic();

        drain_replies();
        repeat (WALK_SETTLE) @(posedge aclk);
        if (failures == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

`default_nettype wire
